>>> design/agl_pkg.sv
// Shared types for the array gcd/lcm unit: controller commands and datapath status.
`default_nettype none

package agl_pkg;

    // Operand pair loaded into the binary gcd engine
    typedef enum logic {
        GSEL_RUN_GCD,   // running gcd with the element magnitude
        GSEL_RUN_LCM    // running lcm with the element magnitude
    } gcd_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     gcd_start;
        gcd_sel_t gcd_sel;
        logic     gcd_step;
        logic     wr_run_gcd;
        logic     div_start;
        logic     div_step;
        logic     mul_start;
        logic     mul_step;
        logic     wr_lcm_first;
        logic     wr_lcm_zero;
        logic     wr_lcm_prod;
        logic     clear_run;
        logic     load_out;
    } agl_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic cnt_done;
        logic is_last;
        logic first;
        logic mag_zero;
        logic lcm_zero;
        logic lcm_held;
    } agl_status_t;

endpackage

`default_nettype wire

>>> design/array_gcd_lcm_unit.sv
// Top level of the array gcd/lcm unit: controller and datapath.
//
//  Channel | Ports                                      | Beat carries
//  --------+--------------------------------------------+------------------------------
//  input   | s_valid s_ready s_value s_is_last          | one array element, last flag
//  result  | m_valid m_ready m_gcd_out m_lcm_out        | gcd, saturated lcm, overflow
//          | m_lcm_overflow                             | (one beat per array)
//
//  Per element the unit runs G1 binary gcd steps on (running gcd, magnitude), at most
//  about twice the sum of both operand widths. The lcm then takes a shortcut (first
//  element, a zero, or held at saturation), or else runs G2 gcd steps on (running lcm,
//  magnitude), LCM_WIDTH divider steps and VALUE_WIDTH multiplier steps. One shared
//  gcd engine runs both the G1 and the G2 steps.
//  Reset (aresetn low, synchronous) clears the running gcd to 0 and the running lcm to 1.
//  A result waiting on m_ready does not block the next element; only a second final
//  element stalls, in its finish state, until the pending beat is taken.
`default_nettype none

module array_gcd_lcm_unit #(
    parameter int VALUE_WIDTH = 16,
    parameter int LCM_WIDTH   = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] s_value,
    input  wire logic                          s_is_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [VALUE_WIDTH-1:0]             m_gcd_out,
    output logic [LCM_WIDTH-1:0]               m_lcm_out,
    output logic                               m_lcm_overflow
);

    // Command and status between sequencer and datapath
    agl_pkg::agl_cmd_t    cmd;
    agl_pkg::agl_status_t sts;

    // Sequencer: owns the handshakes and advances one step per cycle, except while waiting on s_valid or m_ready
    agl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: running state, gcd engine, divider, multiplier, output register
    agl_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LCM_WIDTH   (LCM_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_value        (s_value),
        .s_is_last      (s_is_last),
        .m_gcd_out      (m_gcd_out),
        .m_lcm_out      (m_lcm_out),
        .m_lcm_overflow (m_lcm_overflow)
    );

endmodule

`default_nettype wire

>>> design/agl_ctrl.sv
// Sequencing state machine for the array gcd/lcm unit.
`default_nettype none

module agl_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire agl_pkg::agl_status_t sts,
    output agl_pkg::agl_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_INIT,
        ST_GCD_RUN,
        ST_LCM_PICK,
        ST_LCM_GCD,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_GCD_INIT;
                end
            end
            ST_GCD_INIT: begin
                cmd.gcd_start = 1'b1;
                cmd.gcd_sel   = agl_pkg::GSEL_RUN_GCD;
                state_next    = ST_GCD_RUN;
            end
            ST_GCD_RUN: begin
                if (sts.gcd_done) begin
                    cmd.wr_run_gcd = 1'b1;
                    state_next     = ST_LCM_PICK;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_LCM_PICK: begin
                if (sts.first) begin
                    cmd.wr_lcm_first = 1'b1;
                    state_next       = ST_FINISH;
                end else if (sts.mag_zero || sts.lcm_zero) begin
                    cmd.wr_lcm_zero = 1'b1;
                    state_next      = ST_FINISH;
                end else if (sts.lcm_held) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.gcd_start = 1'b1;
                    cmd.gcd_sel   = agl_pkg::GSEL_RUN_LCM;
                    state_next    = ST_LCM_GCD;
                end
            end
            ST_LCM_GCD: begin
                if (sts.gcd_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (sts.cnt_done) begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_MUL: begin
                if (sts.cnt_done) begin
                    cmd.wr_lcm_prod = 1'b1;
                    state_next      = ST_FINISH;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!sts.is_last) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // Free output slot: publish and start a fresh array
                    cmd.load_out  = 1'b1;
                    cmd.clear_run = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/agl_datapath.sv
// Datapath of the array gcd/lcm unit: binary gcd engine, divider, multiplier, running state.
`default_nettype none

module agl_datapath #(
    parameter int VALUE_WIDTH = 16,
    parameter int LCM_WIDTH   = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire agl_pkg::agl_cmd_t       cmd,
    output agl_pkg::agl_status_t         sts,
    input  wire logic signed [VALUE_WIDTH-1:0] s_value,
    input  wire logic                    s_is_last,
    output logic [VALUE_WIDTH-1:0]       m_gcd_out,
    output logic [LCM_WIDTH-1:0]         m_lcm_out,
    output logic                         m_lcm_overflow
);

    localparam int VW = VALUE_WIDTH;
    localparam int LW = LCM_WIDTH;
    localparam int W  = (LW > VW) ? LW : VW;
    localparam int PW = LW + VW;
    localparam int KW = $clog2(W + 1);
    localparam int CMAX = (LW > VW) ? LW : VW;
    localparam int CW = $clog2(CMAX + 1);
    localparam logic [LW-1:0] LMAX = '1;

    logic [VW-1:0] value_u, mag_in;
    logic [VW-1:0] mag_reg;
    logic          last_reg;

    logic [VW-1:0] run_gcd_reg;
    logic [LW-1:0] run_lcm_reg;
    logic          ovf_reg, first_reg;

    logic [W-1:0]  ga_reg, gb_reg, gres;
    logic [KW-1:0] gk_reg;

    logic [LW-1:0] rem_reg, quo_reg, div_reg;
    logic [LW:0]   trial, diff;

    logic [PW-1:0] prod_reg, mcand_reg;
    logic [VW-1:0] mplier_reg;
    logic [CW-1:0] cnt_reg;

    logic          mag_big, prod_ovf;

    assign value_u = s_value;
    assign mag_in  = value_u[VW-1] ? (~value_u + VW'(1)) : value_u;

    assign gres     = (ga_reg | gb_reg) << gk_reg;
    assign trial    = {rem_reg, quo_reg[LW-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign mag_big  = W'(mag_reg) > W'(LMAX);
    assign prod_ovf = prod_reg[PW-1:LW] != '0;

    assign sts.gcd_done = (ga_reg == '0) || (gb_reg == '0);
    assign sts.cnt_done = (cnt_reg == '0);
    assign sts.is_last  = last_reg;
    assign sts.first    = first_reg;
    assign sts.mag_zero = (mag_reg == '0);
    assign sts.lcm_zero = (run_lcm_reg == '0);
    assign sts.lcm_held = ovf_reg && (run_lcm_reg == LMAX);

    // Running state: reset, per-array clear and per-element updates
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_run) begin
            run_gcd_reg <= '0;
            run_lcm_reg <= LW'(1);
            ovf_reg     <= 1'b0;
            first_reg   <= 1'b1;
        end else begin
            if (cmd.wr_run_gcd) begin
                run_gcd_reg <= VW'(gres);
            end
            if (cmd.wr_lcm_first) begin
                run_lcm_reg <= mag_big ? LMAX : LW'(mag_reg);
                ovf_reg     <= ovf_reg | mag_big;
                first_reg   <= 1'b0;
            end
            if (cmd.wr_lcm_zero) begin
                run_lcm_reg <= '0;
            end
            if (cmd.wr_lcm_prod) begin
                run_lcm_reg <= prod_ovf ? LMAX : prod_reg[LW-1:0];
                ovf_reg     <= ovf_reg | prod_ovf;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            mag_reg  <= mag_in;
            last_reg <= s_is_last;
        end

        if (cmd.gcd_start) begin
            ga_reg <= (cmd.gcd_sel == agl_pkg::GSEL_RUN_LCM) ? W'(run_lcm_reg)
                                                             : W'(run_gcd_reg);
            gb_reg <= W'(mag_reg);
            gk_reg <= '0;
        end else if (cmd.gcd_step) begin
            if (!ga_reg[0] && !gb_reg[0]) begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                gk_reg <= gk_reg + KW'(1);
            end else if (!ga_reg[0]) begin
                ga_reg <= ga_reg >> 1;
            end else if (!gb_reg[0]) begin
                gb_reg <= gb_reg >> 1;
            end else if (ga_reg >= gb_reg) begin
                ga_reg <= ga_reg - gb_reg;
            end else begin
                gb_reg <= gb_reg - ga_reg;
            end
        end

        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= run_lcm_reg;
            div_reg <= LW'(gres);
            cnt_reg <= CW'(LW);
        end else if (cmd.div_step) begin
            rem_reg <= diff[LW] ? trial[LW-1:0] : diff[LW-1:0];
            quo_reg <= {quo_reg[LW-2:0], ~diff[LW]};
            cnt_reg <= cnt_reg - CW'(1);
        end else if (cmd.mul_start) begin
            prod_reg   <= '0;
            mcand_reg  <= PW'(quo_reg);
            mplier_reg <= mag_reg;
            cnt_reg    <= CW'(VW);
        end else if (cmd.mul_step) begin
            if (mplier_reg[0]) begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg - CW'(1);
        end

        if (cmd.load_out) begin
            m_gcd_out      <= run_gcd_reg;
            m_lcm_out      <= run_lcm_reg;
            m_lcm_overflow <= ovf_reg;
        end
    end

endmodule

`default_nettype wire
